FILE: rtl/frame_rate_quality_governor_top_macros.svh
// Assertion macros for the frame-rate quality governor.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef FRAME_RATE_QUALITY_GOVERNOR_TOP_MACROS_SVH
`define FRAME_RATE_QUALITY_GOVERNOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is high
`define FRQG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frqg check failed");

// next-cycle implication, disabled while reset is high
`define FRQG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frqg check failed");

`else

`define FRQG_ASSERT_NOW(label, clk, rst, ante, cons)
`define FRQG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/frqg_pkg.sv
// Package for the frame-rate quality governor: widths, codes, reset values
// and the fade clamp helpers. No dependencies.
package frqg_pkg;

   localparam int TIME_W  = 32;
   localparam int LEVEL_W = 8;
   localparam int IDX_W   = 3;

   // request kinds as seen on the result channel
   typedef enum logic [1:0] {
      REQ_NONE = 2'd0,
      REQ_DOWN = 2'd1,
      REQ_UP   = 2'd2
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [IDX_W-1:0] {
      CSR_SLOW_TH     = 3'd0,
      CSR_FAST_TH     = 3'd1,
      CSR_HOLD        = 3'd2,
      CSR_GRID_MIN    = 3'd3,
      CSR_GRID_MAX    = 3'd4,
      CSR_FADE_STEP   = 3'd5,
      CSR_FLOOR_OBJ   = 3'd6,
      CSR_FLOOR_ACT   = 3'd7
   } csr_index_type;

   localparam logic [LEVEL_W-1:0] GRID_STEP = 8'd1;
   localparam logic [LEVEL_W-1:0] FADE_FULL = 8'd240;

   localparam logic [TIME_W-1:0]  SLOW_TH_RST   = 32'd18182;
   localparam logic [TIME_W-1:0]  FAST_TH_RST   = 32'd15385;
   localparam logic [LEVEL_W-1:0] HOLD_RST      = 8'd5;
   localparam logic [LEVEL_W-1:0] GRID_MIN_RST  = 8'd1;
   localparam logic [LEVEL_W-1:0] GRID_MAX_RST  = 8'd15;
   localparam logic [LEVEL_W-1:0] FADE_STEP_RST = 8'd16;
   localparam logic [LEVEL_W-1:0] FLOOR_RST     = 8'd64;

   // level - step, clamped to floor (level is above floor when used)
   function automatic logic [LEVEL_W-1:0] fade_down(input logic [LEVEL_W-1:0] level,
                                                    input logic [LEVEL_W-1:0] floor_lvl,
                                                    input logic [LEVEL_W-1:0] step);
      logic [LEVEL_W:0] lim;
      lim = {1'b0, floor_lvl} + {1'b0, step};
      if ({1'b0, level} < lim) begin
         return floor_lvl;
      end
      return level - step;
   endfunction

   // level + step, clamped to full fade
   function automatic logic [LEVEL_W-1:0] fade_up(input logic [LEVEL_W-1:0] level,
                                                  input logic [LEVEL_W-1:0] step);
      logic [LEVEL_W:0] sum;
      sum = {1'b0, level} + {1'b0, step};
      if (sum > {1'b0, FADE_FULL}) begin
         return FADE_FULL;
      end
      return sum[LEVEL_W-1:0];
   endfunction

endpackage

FILE: rtl/frame_rate_quality_governor_top.sv
// Frame-rate quality governor, top level.
// Depends on frqg_pkg and frame_rate_quality_governor_top_macros.svh.
//
// Usage:
//   req_* carries one frame timestamp (microseconds, wrapping) per request.
//   rsp_* returns one result per request: the latched request kind, the
//   distant grid count and the two fade levels after that frame.
//   csr_* writes the eight tuning registers by index; write only while idle.
// Path: a request is held in the input register, then in the result register.
// Throughput: one request per cycle while rsp_tready is high. The period
//   compare, the band counter, the grid clamp and the fade clamp all sit
//   between the two registers, so state is ready for the next frame at once.
// Stall: while rsp_tready is low the result register holds; one more
//   request may wait in the input register, then req_tready drops.
// Reset (synchronous, active high): registers return to their defaults,
//   previous timestamp 0, no request, grid at 15, both fades full, both
//   channel stages empty.
module frame_rate_quality_governor_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] frame_time_us
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] request_kind, [9:2] grid_distance,
                                    // [17:10] fade_actors, [25:18] fade_objects,
                                    // [31:26] zero
   // configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

`include "frame_rate_quality_governor_top_macros.svh"

   localparam int TW = frqg_pkg::TIME_W;
   localparam int LW = frqg_pkg::LEVEL_W;

   // ---------------- configuration registers ----------------
   logic [TW-1:0] slow_th_ff, fast_th_ff;
   logic [LW-1:0] hold_ff, grid_min_ff, grid_max_ff, fade_step_ff;
   logic [LW-1:0] floor_obj_ff, floor_act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_th_ff   <= frqg_pkg::SLOW_TH_RST;
         fast_th_ff   <= frqg_pkg::FAST_TH_RST;
         hold_ff      <= frqg_pkg::HOLD_RST;
         grid_min_ff  <= frqg_pkg::GRID_MIN_RST;
         grid_max_ff  <= frqg_pkg::GRID_MAX_RST;
         fade_step_ff <= frqg_pkg::FADE_STEP_RST;
         floor_obj_ff <= frqg_pkg::FLOOR_RST;
         floor_act_ff <= frqg_pkg::FLOOR_RST;
      end else if (csr_we) begin
         unique case (frqg_pkg::csr_index_type'(csr_index))
            frqg_pkg::CSR_SLOW_TH:   slow_th_ff   <= csr_wdata;
            frqg_pkg::CSR_FAST_TH:   fast_th_ff   <= csr_wdata;
            frqg_pkg::CSR_HOLD:      hold_ff      <= csr_wdata[LW-1:0];
            frqg_pkg::CSR_GRID_MIN:  grid_min_ff  <= csr_wdata[LW-1:0];
            frqg_pkg::CSR_GRID_MAX:  grid_max_ff  <= csr_wdata[LW-1:0];
            frqg_pkg::CSR_FADE_STEP: fade_step_ff <= csr_wdata[LW-1:0];
            frqg_pkg::CSR_FLOOR_OBJ: floor_obj_ff <= csr_wdata[LW-1:0];
            frqg_pkg::CSR_FLOOR_ACT: floor_act_ff <= csr_wdata[LW-1:0];
         endcase
      end
   end

   // ---------------- handshake ----------------
   logic          s1_valid_ff;     // input register holds a request
   logic [TW-1:0] s1_time_ff;
   logic          rsp_valid_ff;
   logic          out_free;        // result register can take a new result
   logic          s1_adv;          // request moves from input to result stage
   logic          req_acc;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_time_ff <= req_tdata;
      end
   end

   // ---------------- governor state ----------------
   logic [TW-1:0]             prev_time_ff;
   logic [LW-1:0]             band_cnt_ff, band_cnt_in;
   frqg_pkg::req_kind_type    pend_ff, pend_in;
   logic [LW-1:0]             grid_ff, grid_in;
   logic [LW-1:0]             act_fade_ff, act_fade_in;
   logic [LW-1:0]             obj_fade_ff, obj_fade_in;

   logic [TW-1:0] elapsed;
   logic          is_slow, is_fast, hit;
   logic [LW-1:0] cnt_inc;
   logic [LW:0]   grid_dn_lim, grid_up_sum;
   logic [LW-1:0] grid_dn, grid_up;
   logic          fades_full;

   // band decision and grid update
   always_comb begin
      elapsed     = s1_time_ff - prev_time_ff;
      is_slow     = elapsed > slow_th_ff;
      is_fast     = elapsed < fast_th_ff;
      cnt_inc     = band_cnt_ff + 8'd1;
      hit         = cnt_inc == hold_ff;
      grid_dn_lim = {1'b0, grid_min_ff} + {1'b0, frqg_pkg::GRID_STEP};
      grid_dn     = ({1'b0, grid_ff} < grid_dn_lim) ? grid_min_ff
                                                     : grid_ff - frqg_pkg::GRID_STEP;
      grid_up_sum = {1'b0, grid_ff} + {1'b0, frqg_pkg::GRID_STEP};
      grid_up     = (grid_up_sum > {1'b0, grid_max_ff}) ? grid_max_ff
                                                         : grid_up_sum[LW-1:0];
      fades_full  = (act_fade_ff == frqg_pkg::FADE_FULL) &&
                    (obj_fade_ff == frqg_pkg::FADE_FULL);

      band_cnt_in = band_cnt_ff;
      pend_in     = pend_ff;
      grid_in     = grid_ff;
      // slow wins when both thresholds match
      priority if (is_slow) begin
         band_cnt_in = cnt_inc;
         if (hit) begin
            band_cnt_in = '0;
            grid_in     = grid_dn;
            pend_in     = frqg_pkg::REQ_DOWN;
         end
      end else if (is_fast) begin
         band_cnt_in = cnt_inc;
         if (hit) begin
            band_cnt_in = '0;
            if (fades_full) begin
               grid_in = grid_up;
            end
            pend_in = frqg_pkg::REQ_UP;
         end
      end else begin
         band_cnt_in = '0;
         pend_in     = frqg_pkg::REQ_NONE;
      end
   end

   // fade stepping under the (possibly new) latched request
   always_comb begin
      act_fade_in = act_fade_ff;
      obj_fade_in = obj_fade_ff;
      unique case (pend_in)
         frqg_pkg::REQ_DOWN: begin
            if (grid_in == grid_min_ff) begin
               if (obj_fade_ff > floor_obj_ff) begin
                  obj_fade_in = frqg_pkg::fade_down(obj_fade_ff, floor_obj_ff, fade_step_ff);
               end else if (act_fade_ff > floor_act_ff) begin
                  act_fade_in = frqg_pkg::fade_down(act_fade_ff, floor_act_ff, fade_step_ff);
               end
            end
         end
         frqg_pkg::REQ_UP: begin
            if (act_fade_ff < frqg_pkg::FADE_FULL) begin
               act_fade_in = frqg_pkg::fade_up(act_fade_ff, fade_step_ff);
            end else if (obj_fade_ff < frqg_pkg::FADE_FULL) begin
               obj_fade_in = frqg_pkg::fade_up(obj_fade_ff, fade_step_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         band_cnt_ff  <= '0;
         pend_ff      <= frqg_pkg::REQ_NONE;
         grid_ff      <= frqg_pkg::GRID_MAX_RST;
         act_fade_ff  <= frqg_pkg::FADE_FULL;
         obj_fade_ff  <= frqg_pkg::FADE_FULL;
      end else if (s1_adv) begin
         prev_time_ff <= s1_time_ff;
         band_cnt_ff  <= band_cnt_in;
         pend_ff      <= pend_in;
         grid_ff      <= grid_in;
         act_fade_ff  <= act_fade_in;
         obj_fade_ff  <= obj_fade_in;
      end
   end

   // ---------------- result register ----------------
   logic [31:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= {6'd0, obj_fade_in, act_fade_in, grid_in, pend_in};
      end
   end

   assign rsp_tdata = rsp_data_ff;

   // ---------------- checks ----------------
   // a new request never lands on an input register still holding one
   `FRQG_ASSERT_NOW(a_no_overwrite, clock, reset, req_acc && s1_valid_ff, s1_adv)
   // every request leaving the input stage shows up as a result
   `FRQG_ASSERT_NEXT(a_adv_shows, clock, reset, s1_adv, rsp_valid_ff)
   // fade levels never pass full fade
   `FRQG_ASSERT_NOW(a_fade_range, clock, reset, 1'b1,
      act_fade_ff <= frqg_pkg::FADE_FULL && obj_fade_ff <= frqg_pkg::FADE_FULL)

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for frame_rate_quality_governor_top.
// Streams frame timestamps into the block, predicts every result in the bench
// and compares it field by field. Needs frqg_pkg and the RTL top only.
module tb_top;

   localparam int IDLE_PCT    = 13;    // chance per cycle that a side idles or stalls, percent
   localparam int STALL_LIMIT = 2000;  // cycles with no handshake or register write before giving up
   localparam int PRINT_LIMIT = 50;    // mismatch lines printed; all are counted

   // one result, laid out as rsp_tdata[25:0] (kind in the lowest bits)
   typedef struct packed {
      logic [frqg_pkg::LEVEL_W-1:0] objects;
      logic [frqg_pkg::LEVEL_W-1:0] actors;
      logic [frqg_pkg::LEVEL_W-1:0] grid;
      frqg_pkg::req_kind_type       kind;
   } quality_type;

   // pending stimulus: a frame timestamp or a register write
   typedef struct {
      logic                    is_write;
      frqg_pkg::csr_index_type idx;
      logic [31:0]             value;    // timestamp or register data
      logic                    steady;   // no idling on either side while this frame is in flight
   } stim_entry_type;

   // what kind of frame period to generate; GAP_OUT picks slow or fast per frame
   typedef enum int {GAP_SLOW, GAP_FAST, GAP_BAND, GAP_OUT, GAP_NOISE} gap_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] frame_time_us
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [1:0] kind, [9:2] grid, [17:10] actors, [25:18] objects
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [31:0] csr_wdata  = '0;

   frame_rate_quality_governor_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: register copies and state, starting from their reset values.
   // Register copies are updated on the same edge the block takes the write.
   // ---------------------------------------------------------------------
   logic [31:0]                  slow_th    = frqg_pkg::SLOW_TH_RST;
   logic [31:0]                  fast_th    = frqg_pkg::FAST_TH_RST;
   logic [frqg_pkg::LEVEL_W-1:0] hold_cnt   = frqg_pkg::HOLD_RST;
   logic [frqg_pkg::LEVEL_W-1:0] grid_lo    = frqg_pkg::GRID_MIN_RST;
   logic [frqg_pkg::LEVEL_W-1:0] grid_hi    = frqg_pkg::GRID_MAX_RST;
   logic [frqg_pkg::LEVEL_W-1:0] step_lvl   = frqg_pkg::FADE_STEP_RST;
   logic [frqg_pkg::LEVEL_W-1:0] floor_obj  = frqg_pkg::FLOOR_RST;
   logic [frqg_pkg::LEVEL_W-1:0] floor_act  = frqg_pkg::FLOOR_RST;

   logic [31:0]                  prev_stamp  = '0;
   logic [frqg_pkg::LEVEL_W-1:0] band_cnt    = '0;
   frqg_pkg::req_kind_type       latched_req = frqg_pkg::REQ_NONE;
   logic [frqg_pkg::LEVEL_W-1:0] grid_lvl    = frqg_pkg::GRID_MAX_RST;
   logic [frqg_pkg::LEVEL_W-1:0] actor_lvl   = frqg_pkg::FADE_FULL;
   logic [frqg_pkg::LEVEL_W-1:0] object_lvl  = frqg_pkg::FADE_FULL;

   // stimulus-side view of the thresholds, tracked while the queue is filled
   logic [31:0]                  gen_slow     = frqg_pkg::SLOW_TH_RST;
   logic [31:0]                  gen_fast     = frqg_pkg::FAST_TH_RST;
   logic [frqg_pkg::LEVEL_W-1:0] gen_hold     = frqg_pkg::HOLD_RST;
   logic [31:0]                  stamp_cursor = '0;

   stim_entry_type stim_q[$];
   quality_type    expected_q[$];

   logic req_fire   = 1'b0;   // request taken at the last rising edge
   logic steady_now = 1'b0;
   int   error_count  = 0;
   int   results_seen = 0;
   int   csr_writes   = 0;
   int   downs_seen   = 0;
   int   ups_seen     = 0;
   int   idle_cycles  = 0;

   function automatic logic [frqg_pkg::LEVEL_W-1:0] lower_fade(
         logic [frqg_pkg::LEVEL_W-1:0] level, logic [frqg_pkg::LEVEL_W-1:0] floor_lvl);
      int v;
      v = int'(level) - int'(step_lvl);
      if (v < int'(floor_lvl)) v = int'(floor_lvl);
      return v[frqg_pkg::LEVEL_W-1:0];
   endfunction

   function automatic logic [frqg_pkg::LEVEL_W-1:0] raise_fade(
         logic [frqg_pkg::LEVEL_W-1:0] level);
      int v;
      v = int'(level) + int'(step_lvl);
      if (v > int'(frqg_pkg::FADE_FULL)) v = int'(frqg_pkg::FADE_FULL);
      return v[frqg_pkg::LEVEL_W-1:0];
   endfunction

   // advances the predicted state by one frame and returns the result it gives
   function automatic quality_type predict_quality(logic [31:0] stamp);
      logic [31:0] elapsed;
      int          g;
      quality_type q;
      elapsed    = stamp - prev_stamp;   // wraps modulo 2^32
      prev_stamp = stamp;
      if (elapsed > slow_th) begin
         // slow wins when the thresholds overlap
         band_cnt = band_cnt + 8'd1;
         if (band_cnt == hold_cnt) begin
            band_cnt = '0;
            g = int'(grid_lvl) - int'(frqg_pkg::GRID_STEP);
            if (g < int'(grid_lo)) g = int'(grid_lo);
            grid_lvl    = g[frqg_pkg::LEVEL_W-1:0];
            latched_req = frqg_pkg::REQ_DOWN;
         end
      end else if (elapsed < fast_th) begin
         band_cnt = band_cnt + 8'd1;
         if (band_cnt == hold_cnt) begin
            band_cnt = '0;
            // grid only comes back once both fades are full again
            if (actor_lvl == frqg_pkg::FADE_FULL && object_lvl == frqg_pkg::FADE_FULL) begin
               g = int'(grid_lvl) + int'(frqg_pkg::GRID_STEP);
               if (g > int'(grid_hi)) g = int'(grid_hi);
               grid_lvl = g[frqg_pkg::LEVEL_W-1:0];
            end
            latched_req = frqg_pkg::REQ_UP;
         end
      end else begin
         band_cnt    = '0;
         latched_req = frqg_pkg::REQ_NONE;
      end

      // a latched request keeps stepping the fades every frame
      case (latched_req)
         frqg_pkg::REQ_DOWN: begin
            if (grid_lvl == grid_lo) begin
               if (object_lvl > floor_obj) object_lvl = lower_fade(object_lvl, floor_obj);
               else if (actor_lvl > floor_act) actor_lvl = lower_fade(actor_lvl, floor_act);
            end
         end
         frqg_pkg::REQ_UP: begin
            if (actor_lvl < frqg_pkg::FADE_FULL) actor_lvl = raise_fade(actor_lvl);
            else if (object_lvl < frqg_pkg::FADE_FULL) object_lvl = raise_fade(object_lvl);
         end
         default: ;
      endcase

      q.kind    = latched_req;
      q.grid    = grid_lvl;
      q.actors  = actor_lvl;
      q.objects = object_lvl;
      return q;
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus generation: frame periods chosen against the thresholds that
   // will be in force when the frame reaches the block.
   // ---------------------------------------------------------------------
   function automatic logic [31:0] pick_gap(gap_kind_type k);
      logic [31:0] room;
      logic [31:0] g;
      g = $urandom;
      if (k == GAP_OUT) k = ($urandom_range(1) != 0) ? GAP_SLOW : GAP_FAST;
      case (k)
         GAP_SLOW: begin
            room = 32'hFFFF_FFFF - gen_slow;
            if (room != 0) begin
               if ($urandom_range(15) == 0) g = 32'hFFFF_FFFF;   // longest period
               else g = gen_slow + 32'd1 +
                        $urandom_range((room > 32'd4000) ? 32'd3999 : room - 32'd1);
            end
         end
         GAP_FAST: begin
            if (gen_fast != 0) begin
               if ($urandom_range(15) == 0) g = '0;              // repeated timestamp
               else g = gen_fast - 32'd1 -
                        $urandom_range((gen_fast > 32'd4000) ? 32'd3999 : gen_fast - 32'd1);
            end
         end
         GAP_BAND: begin
            // no band exists when fast is above slow; any period will do then
            if (gen_fast <= gen_slow) begin
               case ($urandom_range(7))
                  0:       g = gen_slow;
                  1:       g = gen_fast;
                  default: g = $urandom_range(gen_slow, gen_fast);
               endcase
            end
         end
         default: ;
      endcase
      return g;
   endfunction

   task automatic queue_frame(logic [31:0] stamp, logic steady);
      stim_entry_type e;
      e.is_write   = 1'b0;
      e.idx        = frqg_pkg::CSR_SLOW_TH;
      e.value      = stamp;
      e.steady     = steady;
      stamp_cursor = stamp;
      stim_q.push_back(e);
   endtask

   task automatic queue_run(gap_kind_type k, int len, logic steady);
      repeat (len) queue_frame(stamp_cursor + pick_gap(k), steady);
   endtask

   // mostly out-of-band runs sized around the hold count, plus band frames and noise
   task automatic queue_mix(int n, logic steady);
      int done;
      int pick;
      int len;
      int span;
      gap_kind_type k;
      span = (gen_hold == 0) ? 256 : gen_hold;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            len = $urandom_range(span + span / 2 + 1, (span > 2) ? span - 2 : 1);
            k   = (pick < 35) ? GAP_SLOW : (pick < 70) ? GAP_FAST : GAP_OUT;
         end else if (pick < 92) begin
            len = $urandom_range(3, 1);
            k   = GAP_BAND;
         end else begin
            len = $urandom_range(4, 1);
            k   = GAP_NOISE;
         end
         if (len > n - done) len = n - done;
         queue_run(k, len, steady);
         done += len;
      end
   endtask

   // narrow registers get random upper data bits; the block keeps only the low byte
   task automatic queue_write(frqg_pkg::csr_index_type idx, logic [31:0] value);
      stim_entry_type e;
      logic [31:0] junk;
      junk = $urandom;
      if (idx != frqg_pkg::CSR_SLOW_TH && idx != frqg_pkg::CSR_FAST_TH)
         value[31:8] = junk[23:0];
      e.is_write = 1'b1;
      e.idx      = idx;
      e.value    = value;
      e.steady   = 1'b0;
      case (idx)
         frqg_pkg::CSR_SLOW_TH: gen_slow = value;
         frqg_pkg::CSR_FAST_TH: gen_fast = value;
         frqg_pkg::CSR_HOLD:    gen_hold = value[7:0];
         default: ;
      endcase
      stim_q.push_back(e);
   endtask

   // ---------------------------------------------------------------------
   // Driver: inputs change on the falling edge. A register write waits at
   // the head of the queue until every predicted result has come back.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive
      stim_entry_type head;
      logic           valid_n;
      logic           write_n;
      if (!reset) begin
         valid_n = req_tvalid && !req_fire;   // hold the request until it is taken
         write_n = 1'b0;
         if (!valid_n && stim_q.size() != 0) begin
            head = stim_q[0];
            if (head.is_write) begin
               if (expected_q.size() == 0) begin
                  write_n = 1'b1;
                  csr_index <= head.idx;
                  csr_wdata <= head.value;
                  void'(stim_q.pop_front());
               end
            end else if (head.steady || $urandom_range(99) >= IDLE_PCT) begin
               valid_n = 1'b1;
               req_tdata <= head.value;
               steady_now = head.steady;
               void'(stim_q.pop_front());
            end
         end
         req_tvalid <= valid_n;
         csr_we     <= write_n;
         rsp_tready <= steady_now || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: samples on the rising edge. Results are checked before the
   // request of the same edge is predicted, since a result is never for a
   // request taken on that same edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      quality_type got;
      quality_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;

         if (rsp_tvalid && rsp_tready) begin
            got = quality_type'(rsp_tdata[25:0]);
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result %h with no request outstanding", rsp_tdata));
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  report_mismatch($sformatf(
                     "result %0d got/exp: kind %0d/%0d grid %0d/%0d act %0d/%0d obj %0d/%0d",
                     results_seen, got.kind, want.kind, got.grid, want.grid,
                     got.actors, want.actors, got.objects, want.objects));
               end
            end
            results_seen++;
            if (got.kind == frqg_pkg::REQ_DOWN) downs_seen++;
            if (got.kind == frqg_pkg::REQ_UP) ups_seen++;
         end

         if (csr_we) begin
            case (csr_index)
               frqg_pkg::CSR_SLOW_TH:   slow_th   = csr_wdata;
               frqg_pkg::CSR_FAST_TH:   fast_th   = csr_wdata;
               frqg_pkg::CSR_HOLD:      hold_cnt  = csr_wdata[7:0];
               frqg_pkg::CSR_GRID_MIN:  grid_lo   = csr_wdata[7:0];
               frqg_pkg::CSR_GRID_MAX:  grid_hi   = csr_wdata[7:0];
               frqg_pkg::CSR_FADE_STEP: step_lvl  = csr_wdata[7:0];
               frqg_pkg::CSR_FLOOR_OBJ: floor_obj = csr_wdata[7:0];
               frqg_pkg::CSR_FLOOR_ACT: floor_act = csr_wdata[7:0];
               default: ;
            endcase
            csr_writes++;
         end

         if (req_tvalid && req_tready) expected_q.push_back(predict_quality(req_tdata));

         // watchdog: any handshake or register write counts as progress
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_q.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence: a directed opening on the reset settings, then phases of
   // random runs, each under its own register settings.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [31:0] base;

      // directed: reset thresholds are slow 18182, fast 15385, hold 5
      queue_frame(32'd16000, 1'b0);                       // first frame, measured from zero
      queue_frame(stamp_cursor, 1'b0);                    // zero period counts as fast
      queue_frame(stamp_cursor + frqg_pkg::SLOW_TH_RST, 1'b0);   // exactly slow threshold
      queue_frame(stamp_cursor + frqg_pkg::FAST_TH_RST, 1'b0);   // exactly fast threshold
      queue_frame(stamp_cursor + frqg_pkg::FAST_TH_RST - 32'd1, 1'b0);   // just fast
      queue_run(GAP_SLOW, 6, 1'b0);                       // reaches hold, latches turn-down
      queue_run(GAP_SLOW, 2, 1'b0);                       // run without latch keeps request
      queue_frame(32'hFFFF_FFFF, 1'b0);                   // top timestamp
      queue_frame(32'h0000_0010, 1'b0);                   // wrap: short period
      queue_run(GAP_FAST, 5, 1'b0);                       // turn-up with fades full
      queue_frame(stamp_cursor + 32'd16000, 1'b0);        // back in band, clears request
      queue_frame(32'hAAAA_5555, 1'b0);
      queue_frame(32'h5555_AAAA, 1'b0);

      // defaults, with neither side idling
      queue_mix(150, 1'b1);

      // latch on every out-of-band frame, narrow grid, fades down to zero
      queue_write(frqg_pkg::CSR_HOLD, 32'd1);
      queue_write(frqg_pkg::CSR_GRID_MIN, 32'd3);
      queue_write(frqg_pkg::CSR_GRID_MAX, 32'd6);
      queue_write(frqg_pkg::CSR_FLOOR_OBJ, 32'd0);
      queue_write(frqg_pkg::CSR_FLOOR_ACT, 32'd0);
      queue_mix(220, 1'b0);

      // fade step equal to full fade; object floor at full fade
      queue_write(frqg_pkg::CSR_FADE_STEP, 32'd240);
      queue_write(frqg_pkg::CSR_FLOOR_OBJ, 32'd240);
      queue_write(frqg_pkg::CSR_FLOOR_ACT, 32'd15);
      queue_write(frqg_pkg::CSR_HOLD, 32'd2);
      queue_mix(150, 1'b0);

      // zero fade step, longest hold
      queue_write(frqg_pkg::CSR_FADE_STEP, 32'd0);
      queue_write(frqg_pkg::CSR_HOLD, 32'd255);
      queue_write(frqg_pkg::CSR_FLOOR_OBJ, 32'd100);
      queue_write(frqg_pkg::CSR_FLOOR_ACT, 32'd100);
      queue_mix(260, 1'b0);

      // overlapping thresholds (slow wins), hold 0 latches on counter wrap, full grid range
      queue_write(frqg_pkg::CSR_SLOW_TH, 32'd0);
      queue_write(frqg_pkg::CSR_FAST_TH, 32'hFFFF_FFFF);
      queue_write(frqg_pkg::CSR_HOLD, 32'd0);
      queue_write(frqg_pkg::CSR_GRID_MIN, 32'd0);
      queue_write(frqg_pkg::CSR_GRID_MAX, 32'd255);
      queue_write(frqg_pkg::CSR_FADE_STEP, 32'd7);
      queue_mix(280, 1'b0);

      // no frame can be out of band
      queue_write(frqg_pkg::CSR_SLOW_TH, 32'hFFFF_FFFF);
      queue_write(frqg_pkg::CSR_FAST_TH, 32'd0);
      queue_mix(30, 1'b0);

      // counter left above a lowered hold count wraps before it latches again
      queue_write(frqg_pkg::CSR_SLOW_TH, 32'd5000);
      queue_write(frqg_pkg::CSR_FAST_TH, 32'd2000);
      queue_write(frqg_pkg::CSR_HOLD, 32'd40);
      queue_run(GAP_SLOW, 30, 1'b0);
      queue_write(frqg_pkg::CSR_HOLD, 32'd10);
      queue_run(GAP_OUT, 240, 1'b0);
      queue_mix(100, 1'b0);

      // random settings; grid minimum may end up above the maximum
      for (int round = 0; round < 3; round++) begin
         base = (round == 2) ? $urandom : $urandom_range(60000, 200);
         queue_write(frqg_pkg::CSR_SLOW_TH, base);
         queue_write(frqg_pkg::CSR_FAST_TH,
                     (round == 2) ? $urandom : base - $urandom_range(base / 2, 0));
         queue_write(frqg_pkg::CSR_HOLD, $urandom_range(12, 1));
         queue_write(frqg_pkg::CSR_GRID_MIN,
                     (round == 2) ? $urandom_range(255) : $urandom_range(20));
         queue_write(frqg_pkg::CSR_GRID_MAX,
                     (round == 2) ? $urandom_range(255) : $urandom_range(30));
         queue_write(frqg_pkg::CSR_FADE_STEP, $urandom_range(40, 1));
         queue_write(frqg_pkg::CSR_FLOOR_OBJ, $urandom_range(240));
         queue_write(frqg_pkg::CSR_FLOOR_ACT, $urandom_range(240));
         queue_mix(120, 1'b0);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: everything sent, everything back, then a few cycles for strays
      while (stim_q.size() != 0 || req_tvalid || expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Summary: %0d frame results checked across %0d register writes",
               results_seen, csr_writes);
      $display("Summary: %0d turn-down and %0d turn-up results, %0d mismatches",
               downs_seen, ups_seen, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
